/* design/rar_pkg.sv */
// ----------------------------------------------------------------------------
// rar_pkg
// shared constants and types for the fraction add and reduce unit
// ----------------------------------------------------------------------------
package rar_pkg;

    // default width of each input fraction part
    localparam int VALUE_WIDTH_DEF = 16;

    // fixed widths of the result fields
    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 32;
    localparam int GCD_OUT_W = 33;

    // width used to sign extend internal values before trimming to a field
    localparam int EXT_W = 64;

    // packed result word, padded to whole bytes
    localparam int OUT_FIELDS_W = NUM_OUT_W + DEN_OUT_W + GCD_OUT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* design/rar_mul.sv */
// ----------------------------------------------------------------------------
// rar_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module rar_mul #(
    parameter int VALUE_WIDTH = rar_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic signed [VALUE_WIDTH-1:0]   i_a,
    input  logic signed [VALUE_WIDTH-1:0]   i_b,
    output logic signed [2*VALUE_WIDTH-1:0] o_p
);

    logic signed [2*VALUE_WIDTH-1:0] r_p;

    // one product per cycle, registered before use
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

/* design/rar_div.sv */
// ----------------------------------------------------------------------------
// rar_div
// radix-2 restoring divider, signed truncating quotient and remainder
// ----------------------------------------------------------------------------
module rar_div #(
    parameter int W = 33
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_dividend,
    input  logic signed [W-1:0] i_divisor,
    output logic signed [W-1:0] o_quo,
    output logic signed [W-1:0] o_rem,
    output rar_pkg::t_div_stat  o_stat
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_qneg;
    logic             r_rneg;

    logic [W-1:0]     dvd_mag;
    logic [W-1:0]     dsr_mag;
    logic [W:0]       shifted;
    logic [W:0]       trial;

    // operand magnitudes
    assign dvd_mag = i_dividend[W-1] ? (~i_dividend + W'(1)) : i_dividend;
    assign dsr_mag = i_divisor[W-1]  ? (~i_divisor  + W'(1)) : i_divisor;

    // one quotient bit per cycle
    assign shifted = {r_rem, r_quo[W-1]};
    assign trial   = shifted - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
                r_quo  <= dvd_mag;
                r_rem  <= '0;
                r_dsr  <= dsr_mag;
                r_qneg <= i_dividend[W-1] ^ i_divisor[W-1];
                r_rneg <= i_dividend[W-1];
            end else if (r_busy) begin
                if (!trial[W]) begin
                    r_rem <= trial[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= shifted[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // sign fix: quotient by both signs, remainder follows the dividend
    assign o_quo = r_qneg ? $signed(~r_quo + W'(1)) : $signed(r_quo);
    assign o_rem = r_rneg ? $signed(~r_rem + W'(1)) : $signed(r_rem);

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    // a new division never starts over one in flight
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    // remainder magnitude stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dsr))
        else $error("divider remainder not below divisor");

    // done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

endmodule

/* design/rational_add_reduce_unit.sv */
// ----------------------------------------------------------------------------
// rational_add_reduce_unit
// adds two signed fractions and reduces the sum by a Euclid gcd
// ----------------------------------------------------------------------------
// Takes one word of four signed parts (a_num, a_den, b_num, b_den, a zero
// denominator counting as one) and returns one word with the reduced sum and
// the gcd as Euclid left it, sign included. One shared multiplier forms the
// cross products and the denominator product unless the denominators match,
// then one radix-2 divider of W = 2*VALUE_WIDTH+1 bits runs every Euclid
// remainder step and, for a nonzero gcd, the two final divisions. s_tready is
// high only while no item is at work, and a result word left waiting in the
// output register holds the next item in its last state.
module rational_add_reduce_unit #(
    parameter int VALUE_WIDTH = rar_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // a_num, a_den, b_num, b_den from bit 0 up, zero padded
    input  logic [((4*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // sum_num (33), sum_den (32), divisor (33) from bit 0 up, zero padded
    output logic [rar_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int VW   = VALUE_WIDTH;
    localparam int W    = 2 * VW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_M0, S_M1, S_M2, S_M3,
        S_GCD, S_GWAIT, S_FIN, S_QNW, S_QD, S_QDW, S_OUT
    } t_state;

    t_state              r_state;
    logic signed [VW-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [W-1:0]  r_n, r_d, r_x, r_y;
    logic                 r_m_tvalid;
    logic [rar_pkg::OUT_DATA_W-1:0] r_m_tdata;

    logic signed [VW-1:0]   in_an, in_ad, in_bn, in_bd;
    logic signed [VW-1:0]   mul_a, mul_b;
    logic signed [2*VW-1:0] mul_p;
    logic signed [W-1:0]    mul_ext;
    logic                   div_start;
    logic signed [W-1:0]    div_dvd, div_dsr, div_quo, div_rem;
    rar_pkg::t_div_stat     div_st;
    logic signed [rar_pkg::EXT_W-1:0] ext_n, ext_d, ext_g;
    logic                   in_acc;

    // input field unpacking
    assign in_an = $signed(s_tdata[VW-1:0]);
    assign in_ad = $signed(s_tdata[2*VW-1:VW]);
    assign in_bn = $signed(s_tdata[3*VW-1:2*VW]);
    assign in_bd = $signed(s_tdata[4*VW-1:3*VW]);

    assign s_tready = (r_state == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // multiplier operand select
    always_comb begin
        unique case (r_state)
            S_M0:    begin mul_a = r_an; mul_b = r_bd; end
            S_M1:    begin mul_a = r_bn; mul_b = r_ad; end
            default: begin mul_a = r_ad; mul_b = r_bd; end
        endcase
    end

    rar_mul #(.VALUE_WIDTH(VW)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign mul_ext = W'(mul_p);

    // divider request: euclid step, then numerator and denominator by gcd
    assign div_start = ((r_state == S_GCD) && (r_y != '0)) ||
                       ((r_state == S_FIN) && (r_x != '0)) ||
                       (r_state == S_QD);

    always_comb begin
        unique case (r_state)
            S_GCD:   begin div_dvd = r_x; div_dsr = r_y; end
            S_FIN:   begin div_dvd = r_n; div_dsr = r_x; end
            default: begin div_dvd = r_d; div_dsr = r_x; end
        endcase
    end

    rar_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_quo      (div_quo),
        .o_rem      (div_rem),
        .o_stat     (div_st)
    );

    // result fields sign extended then trimmed
    assign ext_n = rar_pkg::EXT_W'(r_n);
    assign ext_d = rar_pkg::EXT_W'(r_d);
    assign ext_g = rar_pkg::EXT_W'(r_x);

    // sequencer and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            // word taken downstream; the output state reloads it itself
            if (r_m_tvalid && m_tready && (r_state != S_OUT)) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_an    <= in_an;
                        r_bn    <= in_bn;
                        r_ad    <= (in_ad == '0) ? VW'(1) : in_ad;
                        r_bd    <= (in_bd == '0) ? VW'(1) : in_bd;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_ad == r_bd) begin
                        r_n     <= W'(r_an) + W'(r_bn);
                        r_d     <= W'(r_ad);
                        r_x     <= W'(r_an) + W'(r_bn);
                        r_y     <= W'(r_ad);
                        r_state <= S_GCD;
                    end else begin
                        r_state <= S_M0;
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_n     <= mul_ext;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_n     <= r_n + mul_ext;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_d     <= mul_ext;
                    r_x     <= r_n;
                    r_y     <= mul_ext;
                    r_state <= S_GCD;
                end
                S_GCD: begin
                    r_state <= (r_y == '0) ? S_FIN : S_GWAIT;
                end
                S_GWAIT: begin
                    if (div_st.done) begin
                        r_x     <= r_y;
                        r_y     <= div_rem;
                        r_state <= S_GCD;
                    end
                end
                S_FIN: begin
                    if (r_x == '0) begin
                        r_d     <= W'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_QNW;
                    end
                end
                S_QNW: begin
                    if (div_st.done) begin
                        r_n     <= div_quo;
                        r_state <= S_QD;
                    end
                end
                S_QD: r_state <= S_QDW;
                S_QDW: begin
                    if (div_st.done) begin
                        r_d     <= div_quo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_m_tvalid || m_tready) begin
                        r_m_tdata  <= rar_pkg::OUT_DATA_W'({
                            ext_g[rar_pkg::GCD_OUT_W-1:0],
                            ext_d[rar_pkg::DEN_OUT_W-1:0],
                            ext_n[rar_pkg::NUM_OUT_W-1:0]});
                        r_m_tvalid <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

    // no new word taken while the divider works
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.busy |-> !s_tready)
        else $error("input ready during a division");

    // an accepted word closes the input for the next cycle
    a_accept_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_tready)
        else $error("input ready right after accept");

    // the gcd divides the denominator exactly, so it never reduces to zero
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_d != '0))
        else $error("reduced denominator is zero");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fraction add and reduce unit
// ----------------------------------------------------------------------------
// Drives operand words (two signed fractions) into the slave stream and checks
// every result word against a predictor that adds the fractions and reduces
// the sum with a truncating Euclid gcd. A directed set covers extreme values,
// zero and equal denominators, zero sums and negative gcd signs, then a random
// mix follows. Both stream sides idle at random, and once the result side
// holds off long enough for the unit to stall its input.
// ----------------------------------------------------------------------------

// one predicted result word, fields as they sit in m_tdata
typedef struct {
    logic [32:0] num;
    logic [31:0] den;
    logic [32:0] gcd;
} t_frac_sum;

// holds predicted sums in arrival order and compares result words
class frac_sum_board;
    localparam int VW = rar_pkg::VALUE_WIDTH_DEF;

    t_frac_sum pending_sums[$];
    int        errors;
    int        checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    // add the two fractions and reduce by the truncating euclid gcd
    function t_frac_sum reduce_sum(logic [4*VW-1:0] word);
        longint    an, ad, bn, bd, n, d, x, y, r;
        t_frac_sum res;
        an = $signed(word[0*VW +: VW]);
        ad = $signed(word[1*VW +: VW]);
        bn = $signed(word[2*VW +: VW]);
        bd = $signed(word[3*VW +: VW]);
        if (ad == 0) ad = 1;
        if (bd == 0) bd = 1;
        if (ad != bd) begin
            n = an * bd + bn * ad;
            d = ad * bd;
        end else begin
            n = an + bn;
            d = ad;
        end
        x = n;
        y = d;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        if (x == 0) begin
            d = 1;
        end else begin
            n = n / x;
            d = d / x;
        end
        res.num = n[32:0];
        res.den = d[31:0];
        res.gcd = x[32:0];
        return res;
    endfunction

    function void note_operands(logic [4*VW-1:0] word);
        pending_sums.push_back(reduce_sum(word));
    endfunction

    function void check_sum(logic [rar_pkg::OUT_DATA_W-1:0] word);
        t_frac_sum exp_sum;
        t_frac_sum got;
        got.num = word[32:0];
        got.den = word[64:33];
        got.gcd = word[97:65];
        checked++;
        if (pending_sums.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result word: num %0d den %0d gcd %0d",
                         $signed(got.num), $signed(got.den), $signed(got.gcd));
            return;
        end
        exp_sum = pending_sums.pop_front();
        if (got.num !== exp_sum.num || got.den !== exp_sum.den ||
            got.gcd !== exp_sum.gcd) begin
            errors++;
            if (errors <= 10)
                $display("sum mismatch: exp %0d/%0d gcd %0d, got %0d/%0d gcd %0d",
                         $signed(exp_sum.num), $signed(exp_sum.den),
                         $signed(exp_sum.gcd), $signed(got.num),
                         $signed(got.den), $signed(got.gcd));
        end
    endfunction
endclass

module tb_top;
    localparam int VW         = rar_pkg::VALUE_WIDTH_DEF;
    localparam int IN_W       = ((4 * VW + 7) / 8) * 8;
    localparam int RAND_ITEMS = 350;
    localparam int HOLD_LEN   = 4000;
    localparam int DRAIN_LEN  = 1700;
    localparam int CYCLE_CAP  = 3000000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    // a_num, a_den, b_num, b_den from bit 0 up
    logic [IN_W-1:0]               s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    // sum_num, sum_den, divisor from bit 0 up, zero padded
    logic [rar_pkg::OUT_DATA_W-1:0] m_tdata;

    frac_sum_board board;
    bit            calm;
    int            cycles = 0;

    rational_add_reduce_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle cap against a hung unit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // word monitor on both streams
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready)
            board.note_operands(s_tdata[4*VW-1:0]);
        if (i_rst_n && m_tvalid && m_tready)
            board.check_sum(m_tdata);
    end

    // result side: random stalls, one long hold-off once results flow
    initial begin
        int  hold_cnt;
        int  r;
        bit  pressed;
        hold_cnt = 0;
        pressed  = 1'b0;
        m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_cnt != 0) begin
                hold_cnt--;
            end else if (!calm) begin
                r = $urandom_range(0, 99);
                if (!pressed && board.checked >= 40) begin
                    hold_cnt = HOLD_LEN;
                    pressed  = 1'b1;
                end else if (r < 10) begin
                    hold_cnt = $urandom_range(1, 4);
                end else if (r < 12) begin
                    hold_cnt = $urandom_range(30, 120);
                end
            end
            m_tready <= (hold_cnt == 0);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // one fraction part, weighted toward interesting values
    function automatic logic [VW-1:0] pick_part();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = int'($urandom_range(0, 40)) - 20;
            6: begin
                case ($urandom_range(0, 4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -1;
                    3: v = 1;
                    default: v = 0;
                endcase
            end
            7:          v = 0;
            default:    v = int'($urandom_range(0, 2000)) - 1000;
        endcase
        return v[VW-1:0];
    endfunction

    // offer one operand word and wait for it to be taken
    task automatic send_operands(input logic [VW-1:0] an, ad, bn, bd);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bd, bn, ad, an};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // random word: mostly independent parts, some equal or zero denominators
    task automatic send_random_item();
        logic [VW-1:0] an, ad, bn, bd;
        int            r;
        an = pick_part();
        ad = pick_part();
        bn = pick_part();
        bd = pick_part();
        r  = $urandom_range(0, 99);
        if (r < 20) begin
            bd = ad;
        end else if (r < 25) begin
            bd = ad;
            bn = -an;
        end else if (r < 32) begin
            ad = '0;
        end else if (r < 37) begin
            bd = '0;
        end
        send_operands(an, ad, bn, bd);
    endtask

    // stimulus
    initial begin
        board    = new();
        calm     = 1'b1;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words, back to back with the result side always ready
        send_operands(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_operands(16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_operands(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_operands(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_operands(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768);
        send_operands(16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767);
        send_operands(-16'sd32768, -16'sd1, 16'sd32767, 16'sd1);
        send_operands(16'sd5, 16'sd0, 16'sd3, 16'sd0);
        send_operands(16'sd5, 16'sd0, 16'sd3, 16'sd7);
        send_operands(16'sd5, 16'sd7, 16'sd3, 16'sd0);
        send_operands(16'sd3, -16'sd4, -16'sd3, -16'sd4);
        send_operands(16'sd1, -16'sd6, 16'sd1, 16'sd4);
        send_operands(-16'sd7, 16'sd6, 16'sd2, -16'sd9);
        send_operands(16'sd17711, 16'sd28657, 16'sd0, 16'sd1);
        send_operands(-16'sd10946, -16'sd17711, 16'sd0, 16'sd1);
        send_operands(16'sd1, 16'sd1, -16'sd1, 16'sd1);
        send_operands(16'sd0, 16'sd5, 16'sd0, -16'sd5);
        send_operands(16'sd32767, -16'sd1, -16'sd32768, -16'sd32768);
        send_operands(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_operands(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_operands(16'hAAAA, 16'h5555, 16'h7FFF, 16'h8001);

        // random words with idling on both sides
        calm = 1'b0;
        repeat (RAND_ITEMS) send_random_item();
        s_tvalid <= 1'b0;

        // drain, then give a late extra word time to show up
        while (board.pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);
        board.errors += board.pending_sums.size();
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
